>>> hw/rtl/nfrc_pkg.sv
package nfrc_pkg;

   localparam int RATE_W     = 19;
   localparam int MUL_A_W    = RATE_W + 1;
   localparam int PROD_W     = MUL_A_W + RATE_W;
   localparam int MAX_COPIES = 64;
   localparam int COPY_W     = $clog2(MAX_COPIES + 1);
   localparam int CSR_IDX_W  = 2;

   typedef logic [RATE_W-1:0]    rate_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_INPUT_RATE  = 2'd0;
   localparam csr_idx_type CSR_OUTPUT_RATE = 2'd1;

   localparam rate_type INPUT_RATE_RST  = 19'd44100;
   localparam rate_type OUTPUT_RATE_RST = 19'd48000;

   typedef struct packed {
      rate_type in_rate;
      rate_type out_rate;
      logic     clear;
   } rate_cfg_type;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_EQ       = 7'b0000010,
      ST_LIM_MUL  = 7'b0000100,
      ST_LIM_HOLD = 7'b0001000,
      ST_SRC_MUL  = 7'b0010000,
      ST_CMP      = 7'b0100000,
      ST_WRAP     = 7'b1000000
   } state_type;

   function automatic rate_type eff_rate(input rate_type r);
      return (r == '0) ? rate_type'(1) : r;
   endfunction

endpackage

>>> hw/rtl/nfrc_if.sv
interface nfrc_req_if #(parameter int FRAME_BITS = 64) ();
   logic                  valid;
   logic                  ready;
   logic [FRAME_BITS-1:0] frame_data;

   modport source (output valid, output frame_data, input ready);
   modport sink (input valid, input frame_data, output ready);
endinterface

interface nfrc_rsp_if #(parameter int FRAME_BITS = 64) ();
   logic                  valid;
   logic                  ready;
   logic [FRAME_BITS-1:0] out_frame;
   logic                  last_copy;

   modport source (output valid, output out_frame, output last_copy, input ready);
   modport sink (input valid, input out_frame, input last_copy, output ready);
endinterface

interface nfrc_csr_if ();
   logic                   valid;
   logic                   ready;
   nfrc_pkg::csr_idx_type  index;
   nfrc_pkg::rate_type     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/nearest_frame_rate_converter.sv
// Drop-or-repeat frame rate converter, one whole audio frame per word.
// req_bus carries input frames, rsp_bus the copies, each with last_copy set
// on the final copy for its input frame; a frame may give no copy at all.
// csr_bus writes input_rate (index 0) or output_rate (index 1); either write
// clears both frame counts. A rate of zero acts as one.
// Each pending output index is tested against the arriving frame by one
// shared registered 20x19 multiplier: out_count*input_rate is compared with
// (in_count+1)*output_rate. The sequencer takes one frame at a time and
// drops req_bus.ready until that frame is finished.
// Per frame: one limit product, then one multiply and test per candidate copy,
// or no multiply at all when the rates are equal; at most 64 copies per frame.
// A copy sits in an output register; while rsp_bus stalls the sequencer
// holds at the next copy, and the next frame can be taken while the
// final copy still waits.
// Reset (synchronous) restores 44100 and 48000 and clears the counts.
module nearest_frame_rate_converter #(
   parameter int FRAME_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   nfrc_req_if.sink    req_bus,
   nfrc_rsp_if.source  rsp_bus,
   nfrc_csr_if.sink    csr_bus
);

   nfrc_pkg::rate_cfg_type           rate_cfg;
   nfrc_pkg::state_type              state_ff, state_in;
   logic [FRAME_BITS-1:0]            frame_ff, frame_in;
   nfrc_pkg::rate_type               in_count_ff, in_count_in;
   nfrc_pkg::rate_type               out_count_ff, out_count_in;
   logic [nfrc_pkg::COPY_W-1:0]      copies_ff, copies_in;
   logic                             pend_ff, pend_in;
   logic [nfrc_pkg::PROD_W-1:0]      lim_ff, lim_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [FRAME_BITS-1:0]            rsp_frame_ff, rsp_frame_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic [nfrc_pkg::MUL_A_W-1:0]     mul_a;
   nfrc_pkg::rate_type               mul_b;
   logic [nfrc_pkg::PROD_W-1:0]      prod;
   nfrc_pkg::rate_type               in_next;
   logic                             wrap;
   logic                             hit;
   logic                             out_free;
   logic                             load;
   logic                             load_last;

   nfrc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_bus  (csr_bus),
      .rate_cfg (rate_cfg)
   );

   always_comb begin
      if (state_ff == nfrc_pkg::ST_LIM_MUL) begin
         mul_a = {1'b0, in_next};
         mul_b = rate_cfg.out_rate;
      end else begin
         mul_a = {1'b0, out_count_ff};
         mul_b = rate_cfg.in_rate;
      end
   end

   nfrc_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   assign in_next  = in_count_ff + 1'b1;
   assign wrap     = (in_next == rate_cfg.in_rate);
   assign hit      = (prod < lim_ff) &&
                     (copies_ff != nfrc_pkg::COPY_W'(nfrc_pkg::MAX_COPIES));
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready     = (state_ff == nfrc_pkg::ST_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_frame = rsp_frame_ff;
   assign rsp_bus.last_copy = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      frame_in     = frame_ff;
      in_count_in  = in_count_ff;
      out_count_in = out_count_ff;
      copies_in    = copies_ff;
      pend_in      = pend_ff;
      lim_in       = lim_ff;
      load         = 1'b0;
      load_last    = 1'b0;

      unique case (state_ff)
         nfrc_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               frame_in  = req_bus.frame_data;
               copies_in = '0;
               pend_in   = 1'b0;
               state_in  = (rate_cfg.in_rate == rate_cfg.out_rate) ?
                           nfrc_pkg::ST_EQ : nfrc_pkg::ST_LIM_MUL;
            end
         end
         nfrc_pkg::ST_EQ: begin
            if (out_free) begin
               load         = 1'b1;
               load_last    = 1'b1;
               out_count_in = out_count_ff + 1'b1;
               state_in     = nfrc_pkg::ST_WRAP;
            end
         end
         nfrc_pkg::ST_LIM_MUL: begin
            state_in = nfrc_pkg::ST_LIM_HOLD;
         end
         nfrc_pkg::ST_LIM_HOLD: begin
            lim_in   = prod;
            state_in = nfrc_pkg::ST_CMP;
         end
         nfrc_pkg::ST_SRC_MUL: begin
            state_in = nfrc_pkg::ST_CMP;
         end
         nfrc_pkg::ST_CMP: begin
            // the previous copy goes out once we know whether it is the last
            if (!pend_ff || out_free) begin
               load = pend_ff;
               if (hit) begin
                  pend_in      = 1'b1;
                  copies_in    = copies_ff + 1'b1;
                  out_count_in = out_count_ff + 1'b1;
                  state_in     = nfrc_pkg::ST_SRC_MUL;
               end else begin
                  load_last = 1'b1;
                  pend_in   = 1'b0;
                  state_in  = nfrc_pkg::ST_WRAP;
               end
            end
         end
         nfrc_pkg::ST_WRAP: begin
            if (wrap) begin
               in_count_in  = '0;
               out_count_in = (out_count_ff >= rate_cfg.out_rate) ?
                              out_count_ff - rate_cfg.out_rate : '0;
            end else begin
               in_count_in = in_next;
            end
            state_in = nfrc_pkg::ST_IDLE;
         end
         default: begin
            state_in = nfrc_pkg::ST_IDLE;
         end
      endcase

      if (rate_cfg.clear) begin
         in_count_in  = '0;
         out_count_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_frame_in = rsp_frame_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_frame_in = frame_ff;
         rsp_last_in  = load_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nfrc_pkg::ST_IDLE;
         in_count_ff  <= '0;
         out_count_ff <= '0;
         copies_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         copies_ff    <= copies_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff     <= frame_in;
      lim_ff       <= lim_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_last_ff  <= rsp_last_in;
   end

   a_copies_bounded: assert property (@(posedge clock) disable iff (reset)
      copies_ff <= nfrc_pkg::COPY_W'(nfrc_pkg::MAX_COPIES))
      else $error("copy count above limit");

   a_in_count_below_rate: assert property (@(posedge clock) disable iff (reset)
      in_count_ff < rate_cfg.in_rate)
      else $error("input count not below input rate");

   a_fresh_frame: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (copies_ff == '0) && !pend_ff)
      else $error("new frame started with stale copy state");

endmodule

>>> hw/rtl/nfrc_csr.sv
module nfrc_csr (
   input  logic                   clock,
   input  logic                   reset,
   nfrc_csr_if.sink               csr_bus,
   output nfrc_pkg::rate_cfg_type rate_cfg
);

   nfrc_pkg::rate_type in_rate_ff, in_rate_in;
   nfrc_pkg::rate_type out_rate_ff, out_rate_in;
   logic               hit;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      in_rate_in  = in_rate_ff;
      out_rate_in = out_rate_ff;
      hit         = 1'b0;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            nfrc_pkg::CSR_INPUT_RATE: begin
               in_rate_in = csr_bus.data;
               hit        = 1'b1;
            end
            nfrc_pkg::CSR_OUTPUT_RATE: begin
               out_rate_in = csr_bus.data;
               hit         = 1'b1;
            end
            default: begin
               hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_rate_ff  <= nfrc_pkg::INPUT_RATE_RST;
         out_rate_ff <= nfrc_pkg::OUTPUT_RATE_RST;
      end else begin
         in_rate_ff  <= in_rate_in;
         out_rate_ff <= out_rate_in;
      end
   end

   assign rate_cfg.in_rate  = nfrc_pkg::eff_rate(in_rate_ff);
   assign rate_cfg.out_rate = nfrc_pkg::eff_rate(out_rate_ff);
   assign rate_cfg.clear    = hit;

endmodule

>>> hw/rtl/nfrc_mul.sv
module nfrc_mul (
   input  logic                              clock,
   input  logic [nfrc_pkg::MUL_A_W-1:0]      mul_a,
   input  nfrc_pkg::rate_type                mul_b,
   output logic [nfrc_pkg::PROD_W-1:0]       prod_ff
);

   logic [nfrc_pkg::PROD_W-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule
